[hdl/ptfb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptfb_pkg
// shared widths, codes and controller/datapath interface types for the
// polyline tangent/normal/binormal frame builder
// ----------------------------------------------------------------------------
package ptfb_pkg;

   // vertex coordinate width (signed q16.16) and unit vector fraction bits
   localparam int COORD_WIDTH    = 32;
   localparam int UNIT_FRAC_BITS = 14;

   // unit vector components carry one sign bit and one integer bit
   localparam int UNIT_W = UNIT_FRAC_BITS + 2;
   localparam int UNIT   = 1 << UNIT_FRAC_BITS;
   localparam int OUT_W  = 16;

   // stream payload widths
   localparam int IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_W = 9 * OUT_W;

   // normalizer: magnitudes are scaled into [2^23, 2^24)
   localparam int MAG_W  = 24;
   localparam int NMW    = (COORD_WIDTH + 1 > MAG_W) ? COORD_WIDTH + 1 : MAG_W;
   localparam int SRC_W  = NMW + 1;
   localparam int MUL_W  = MAG_W + 2;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SUM_W  = 2 * MAG_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int QW     = UNIT_FRAC_BITS + 1;
   localparam int NUM_W  = MAG_W + UNIT_FRAC_BITS + 1;
   localparam int DRW    = ROOT_W + 1;
   localparam int CNT_W  = $clog2(ROOT_W);

   // threshold registers, unsigned q1.14
   localparam int THR_W       = 15;
   localparam int THR_X_W     = THR_W + 8;
   localparam int THR_SHL     = (UNIT_FRAC_BITS >= 14) ? UNIT_FRAC_BITS - 14 : 0;
   localparam int THR_SHR     = (UNIT_FRAC_BITS >= 14) ? 0 : 14 - UNIT_FRAC_BITS;
   localparam int CSR_IDX_W   = 1;
   localparam logic [THR_W-1:0] FIRST_THR_RST = 15'd16351;
   localparam logic [THR_W-1:0] REST_THR_RST  = 15'd16381;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIRST_UP_THR,
      REG_REST_UP_THR
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG,
      ST_SCALE,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_NORM_DONE,
      ST_SETUP,
      ST_CROSS,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SC_NONE,
      SC_SHR1,
      SC_SHL4,
      SC_SHL1
   } scale_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLR,
      ACC_ADD,
      ACC_LOAD,
      ACC_SUBN
   } acc_op_type;

   typedef enum logic {
      MUL_SQ,
      MUL_CROSS
   } mul_mode_type;

   typedef struct packed {
      logic         capture;
      logic         load_prev;
      logic         reset_tan;
      logic         load_seg;
      logic         frame_setup;
      logic         first;
      scale_op_type scale;
      acc_op_type   acc_op;
      mul_mode_type mul_mode;
      logic [2:0]   mul_idx;
      logic [1:0]   n_idx;
      logic         sqrt_step;
      logic         div_init;
      logic         div_step;
      logic         to_t;
      logic         to_bn;
      logic         emit;
      logic         emit_last;
      logic         commit;
   } dp_cmd_type;

   typedef struct packed {
      logic zero;
      logic big;
      logic small19;
      logic small23;
      logic out_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

[hdl/ptfb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptfb_ctrl
// sequencer for segment normalization, frame setup, cross products and emit
// ----------------------------------------------------------------------------
module ptfb_ctrl import ptfb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tlast,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             seen_ff, seen_in;
   logic             first_pend_ff, first_pend_in;
   logic             last_ff, last_in;
   logic             frame2_ff, frame2_in;
   logic             phase_bn_ff, phase_bn_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         seen_ff       <= 1'b0;
         first_pend_ff <= 1'b1;
         last_ff       <= 1'b0;
         frame2_ff     <= 1'b0;
         phase_bn_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         seen_ff       <= seen_in;
         first_pend_ff <= first_pend_in;
         last_ff       <= last_in;
         frame2_ff     <= frame2_in;
         phase_bn_ff   <= phase_bn_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      first_pend_in = first_pend_ff;
      last_in       = last_ff;
      frame2_in     = frame2_ff;
      phase_bn_in   = phase_bn_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.scale     = SC_NONE;
      cmd.acc_op    = ACC_HOLD;
      cmd.mul_mode  = MUL_SQ;
      cmd.mul_idx   = cnt_ff[2:0];
      cmd.n_idx     = cnt_ff[2:1] - 2'd1;
      cmd.first     = first_pend_ff & ~frame2_ff;
      cmd.emit_last = frame2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (!seen_ff) begin
                  // first vertex of a run only seeds the segment origin
                  cmd.load_prev = 1'b1;
                  if (req_tlast) begin
                     cmd.reset_tan = 1'b1;
                     first_pend_in = 1'b1;
                  end else begin
                     seen_in = 1'b1;
                  end
               end else begin
                  last_in  = req_tlast;
                  state_in = ST_SEG;
               end
            end
         end
         ST_SEG: begin
            cmd.load_seg = 1'b1;
            phase_bn_in  = 1'b0;
            frame2_in    = 1'b0;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cnt_in = '0;
            priority if (stat.zero) begin
               state_in = ST_NORM_DONE;
            end else if (stat.big) begin
               cmd.scale = SC_SHR1;
            end else if (stat.small19) begin
               cmd.scale = SC_SHL4;
            end else if (stat.small23) begin
               cmd.scale = SC_SHL1;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.mul_mode = MUL_SQ;
            cmd.acc_op   = (cnt_ff == '0) ? ACC_CLR : ACC_ADD;
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               cnt_in   = '0;
               state_in = ST_NORM_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_NORM_DONE: begin
            cnt_in = '0;
            if (phase_bn_ff) begin
               cmd.to_bn = 1'b1;
               state_in  = ST_CROSS;
            end else begin
               cmd.to_t = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.frame_setup = 1'b1;
            phase_bn_in     = 1'b1;
            state_in        = ST_SCALE;
         end
         ST_CROSS: begin
            // products issue on counts 0..5, accumulate one count later
            cmd.mul_mode = MUL_CROSS;
            unique case (cnt_ff[2:0])
               3'd1, 3'd3, 3'd5: cmd.acc_op = ACC_LOAD;
               3'd2, 3'd4, 3'd6: cmd.acc_op = ACC_SUBN;
               default:          cmd.acc_op = ACC_HOLD;
            endcase
            if (cnt_ff == CNT_W'(6)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               if (!frame2_ff && last_ff) begin
                  frame2_in = 1'b1;
                  state_in  = ST_SETUP;
               end else begin
                  cmd.commit    = 1'b1;
                  first_pend_in = 1'b0;
                  if (last_ff) begin
                     cmd.reset_tan = 1'b1;
                     seen_in       = 1'b0;
                     first_pend_in = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[hdl/ptfb_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptfb_dpath
// vector registers, shared multiplier, bit-serial square root, three-lane
// divider, threshold registers and result register
// ----------------------------------------------------------------------------
module ptfb_dpath import ptfb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [THR_W-1:0]      csr_wdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (UNIT_FRAC_BITS - 1);

   logic signed [COORD_WIDTH-1:0] vin_ff [3];
   logic signed [COORD_WIDTH-1:0] prev_v_ff [3];
   logic signed [UNIT_W-1:0]      prev_t_ff [3];
   logic signed [UNIT_W-1:0]      t_ff [3];
   logic signed [UNIT_W-1:0]      bn_ff [3];
   logic signed [UNIT_W-1:0]      n_ff [3];
   logic signed [UNIT_W-1:0]      nt [3];
   logic signed [UNIT_W-1:0]      nval [3];
   logic [NMW-1:0]                mag_ff [3];
   logic                          neg_ff [3];
   logic signed [SRC_W-1:0]       src [3];
   logic [SRC_W-1:0]              src_abs [3];
   logic [DRW-1:0]                drem_ff [3];
   logic [QW-1:0]                 dlo_ff [3];
   logic [QW-1:0]                 q_ff [3];
   logic [QW-1:0]                 qc [3];
   logic [SUM_W-1:0]              acc_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic [ROOT_W-1:0]             root_ff;
   logic [REM_W-1:0]              rem_ff, rem2, trial;
   logic                          seg_deg_ff, bz_ff, nt_neg_ff;
   logic [THR_W-1:0]              thr_first_ff, thr_rest_ff;
   logic [THR_X_W-1:0]            thr_x;
   logic                          use_x;
   logic                          out_valid_ff, out_deg_ff, out_last_ff;
   logic [OUT_DATA_W-1:0]         out_data_ff;

   function automatic logic signed [UNIT_W-1:0] round_unit(
      input logic signed [SUM_W-1:0] p
   );
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] r;
      a = p[SUM_W-1] ? SUM_W'(-p) : SUM_W'(p);
      r = (a + HALF) >> UNIT_FRAC_BITS;
      if (r > SUM_W'(UNIT)) r = SUM_W'(UNIT);
      return p[SUM_W-1] ? -UNIT_W'(r) : UNIT_W'(r);
   endfunction

   // threshold select, rescaled to the unit fraction width
   always_comb begin
      thr_x = (THR_X_W'(cmd.first ? thr_first_ff : thr_rest_ff) << THR_SHL) >> THR_SHR;
      use_x = t_ff[1] > $signed({1'b0, thr_x[UNIT_W-2:0]});
   end

   // normalizer operand: segment or tangent x up
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         src[i] = SRC_W'(vin_ff[i]) - SRC_W'(prev_v_ff[i]);
      end
      if (cmd.frame_setup) begin
         if (use_x) begin
            src[0] = '0;
            src[1] = SRC_W'(t_ff[2]);
            src[2] = -SRC_W'(t_ff[1]);
         end else begin
            src[0] = -SRC_W'(t_ff[2]);
            src[1] = '0;
            src[2] = SRC_W'(t_ff[0]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         src_abs[i] = src[i][SRC_W-1] ? SRC_W'(-src[i]) : SRC_W'(src[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.load_seg || cmd.frame_setup) begin
            mag_ff[i] <= src_abs[i][NMW-1:0];
            neg_ff[i] <= src[i][SRC_W-1];
         end else begin
            unique case (cmd.scale)
               SC_SHR1: mag_ff[i] <= mag_ff[i] >> 1;
               SC_SHL4: mag_ff[i] <= mag_ff[i] << 4;
               SC_SHL1: mag_ff[i] <= mag_ff[i] << 1;
               default: mag_ff[i] <= mag_ff[i];
            endcase
         end
      end
      if (cmd.frame_setup) nt_neg_ff <= use_x & ~cmd.first;
   end

   always_comb begin
      stat.zero     = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
      stat.big      = 1'b0;
      stat.small19  = 1'b1;
      stat.small23  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, mag_ff[i]} >= ((NMW + 1)'(1) << MAG_W)) stat.big = 1'b1;
         if (mag_ff[i] >= (NMW'(1) << (MAG_W - 5))) stat.small19 = 1'b0;
         if (mag_ff[i] >= (NMW'(1) << (MAG_W - 1))) stat.small23 = 1'b0;
      end
      stat.out_busy = out_valid_ff;
   end

   // shared multiplier
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nt[i] = nt_neg_ff ? -t_ff[i] : t_ff[i];
      end
      mul_a = '0;
      mul_b = '0;
      if (cmd.mul_mode == MUL_SQ) begin
         unique case (cmd.mul_idx)
            3'd0: mul_a = $signed({2'b00, mag_ff[0][MAG_W-1:0]});
            3'd1: mul_a = $signed({2'b00, mag_ff[1][MAG_W-1:0]});
            3'd2: mul_a = $signed({2'b00, mag_ff[2][MAG_W-1:0]});
            default: mul_a = '0;
         endcase
         mul_b = mul_a;
      end else begin
         unique case (cmd.mul_idx)
            3'd0: begin mul_a = MUL_W'(bn_ff[1]); mul_b = MUL_W'(nt[2]); end
            3'd1: begin mul_a = MUL_W'(bn_ff[2]); mul_b = MUL_W'(nt[1]); end
            3'd2: begin mul_a = MUL_W'(bn_ff[2]); mul_b = MUL_W'(nt[0]); end
            3'd3: begin mul_a = MUL_W'(bn_ff[0]); mul_b = MUL_W'(nt[2]); end
            3'd4: begin mul_a = MUL_W'(bn_ff[0]); mul_b = MUL_W'(nt[1]); end
            3'd5: begin mul_a = MUL_W'(bn_ff[1]); mul_b = MUL_W'(nt[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // accumulator doubles as the radicand shift register
   always_comb begin
      rem2  = {rem_ff[REM_W-3:0], acc_ff[SUM_W-1 -: 2]};
      trial = REM_W'({root_ff, 2'b01});
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_step) begin
         acc_ff <= acc_ff << 2;
         if (rem2 >= trial) begin
            rem_ff  <= rem2 - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem2;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end else begin
         unique case (cmd.acc_op)
            ACC_CLR: begin
               acc_ff  <= '0;
               rem_ff  <= '0;
               root_ff <= '0;
            end
            ACC_ADD:  acc_ff <= acc_ff + prod_ff[SUM_W-1:0];
            ACC_LOAD: acc_ff <= prod_ff[SUM_W-1:0];
            ACC_SUBN: n_ff[cmd.n_idx] <= round_unit($signed(acc_ff - prod_ff[SUM_W-1:0]));
            default:  acc_ff <= acc_ff;
         endcase
      end
   end

   // three divider lanes, one quotient bit each per cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.div_init) begin
            logic [NUM_W-1:0] num;
            num        = {1'b0, mag_ff[i][MAG_W-1:0], UNIT_FRAC_BITS'(0)} +
                         NUM_W'(root_ff >> 1);
            drem_ff[i] <= DRW'(num[NUM_W-1:QW]);
            dlo_ff[i]  <= num[QW-1:0];
            q_ff[i]    <= '0;
         end else if (cmd.div_step) begin
            logic [DRW:0] tr;
            tr = {drem_ff[i], dlo_ff[i][QW-1]};
            if (tr >= (DRW + 1)'(root_ff)) begin
               drem_ff[i] <= DRW'(tr - (DRW + 1)'(root_ff));
               q_ff[i]    <= {q_ff[i][QW-2:0], 1'b1};
            end else begin
               drem_ff[i] <= tr[DRW-1:0];
               q_ff[i]    <= {q_ff[i][QW-2:0], 1'b0};
            end
            dlo_ff[i] <= dlo_ff[i] << 1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i]   = (q_ff[i] > QW'(UNIT)) ? QW'(UNIT) : q_ff[i];
         nval[i] = neg_ff[i] ? -UNIT_W'(qc[i]) : UNIT_W'(qc[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.capture) vin_ff[i] <= req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
         if (cmd.to_t) t_ff[i] <= stat.zero ? prev_t_ff[i] : nval[i];
         if (cmd.to_bn) bn_ff[i] <= stat.zero ? '0 : nval[i];
      end
      if (cmd.to_t) seg_deg_ff <= stat.zero;
      if (cmd.to_bn) bz_ff <= stat.zero;
   end

   // run state and threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prev_v_ff[i] <= '0;
            prev_t_ff[i] <= (i == 0) ? UNIT_W'(UNIT) : '0;
         end
         thr_first_ff <= FIRST_THR_RST;
         thr_rest_ff  <= REST_THR_RST;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.load_prev) prev_v_ff[i] <= req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            else if (cmd.commit) prev_v_ff[i] <= vin_ff[i];
            if (cmd.reset_tan) prev_t_ff[i] <= (i == 0) ? UNIT_W'(UNIT) : '0;
            else if (cmd.commit) prev_t_ff[i] <= t_ff[i];
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               REG_FIRST_UP_THR: thr_first_ff <= csr_wdata;
               REG_REST_UP_THR:  thr_rest_ff  <= csr_wdata;
               default:          thr_first_ff <= thr_first_ff;
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         for (int i = 0; i < 3; i++) begin
            out_data_ff[i*OUT_W +: OUT_W]       <= OUT_W'(t_ff[i]);
            out_data_ff[(3 + i)*OUT_W +: OUT_W] <= OUT_W'(n_ff[i]);
            out_data_ff[(6 + i)*OUT_W +: OUT_W] <= OUT_W'(bn_ff[i]);
         end
         out_deg_ff  <= seg_deg_ff | bz_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_deg_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

[hdl/polyline_tnb_frame_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_tnb_frame_builder
// tangent/normal/binormal frames along a stream of polyline vertices
// ----------------------------------------------------------------------------
// vertices (signed q16.16) arrive one request at a time, tlast closing a run.
// every vertex after the first yields the frame of the previous vertex: unit
// tangent of the segment, binormal = normalize(tangent x up) with up the y
// axis or, when tangent y exceeds a threshold, the x axis, and normal =
// binormal x tangent (tangent negated for later frames in the x axis case).
// the closing vertex yields a second frame tagged tlast. a zero segment
// reuses the previous tangent and a zero binormal gives zero binormal and
// normal; either sets tuser. a one-vertex run yields nothing. the first
// vertex of a run only seeds the segment origin; every other vertex makes
// two passes through the normalizer (each a 25-step bit-serial square
// root and a 15-step three-lane divider, plus up to eight scaling steps)
// and six cross-product terms on one shared multiplier before its frame.
// a zero-length segment or a zero binormal skips the square root and
// divide of its pass. a closing vertex repeats the binormal pass and the
// cross products for its second frame. a frame waits while the previous
// one still sits unaccepted in the output register, which holds it while
// the next one is built. no new vertex is taken until its frames are out.
// csr registers: index 0 first-frame threshold, index 1 later-frame
// threshold, both unsigned q1.14; write them only while the block is idle.
// ----------------------------------------------------------------------------
module polyline_tnb_frame_builder import ptfb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // vertex requests
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,   // vertex_x, vertex_y, vertex_z
   input  wire logic                  req_tlast,   // vertex_last
   // frame results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0]      rsp_tdata,   // tangent_x/y/z, normal_x/y/z, binormal_x/y/z
   output logic                       rsp_tuser,   // degenerate
   output logic                       rsp_tlast,   // frame_last
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [THR_W-1:0]      csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // run sequencing
   ptfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic and result register
   ptfb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[tb/sv/polyline_tnb_frame_builder_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_tnb_frame_builder_tb
// self-checking bench for the polyline frame builder
// ----------------------------------------------------------------------------
// a predictor in this module tracks the run state and computes the frames
// that each vertex request yields. the frames go into a queue and are
// compared as a whole with what the block sends back. there is a short
// directed part with extreme, degenerate and up-vector-switching cases, then
// random polylines under several threshold settings. random idling is used
// on both sides.
// ----------------------------------------------------------------------------
module polyline_tnb_frame_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptfb_pkg::*;

   typedef struct packed {
      logic        frame_last;
      logic        degenerate;
      logic [15:0] bz, by, bx, nz, ny, nx, tz, ty, tx;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0] csr_wdata = '0;

   polyline_tnb_frame_builder dut (.*);

   always #10 clock = ~clock;

   // predictor state
   longint prev_vtx [3];
   longint prev_tan [3];
   bit     vtx_seen;
   bit     first_pending;
   int     first_thr = 16351;
   int     rest_thr = 16381;

   frame_type frames_expected[$];
   int   errors = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   quiet_cycles = 0;

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // unit vector with UNIT_FRAC_BITS fraction bits; zero vector gives 0
   function automatic bit make_unit(input longint v [3], output longint u [3]);
      longint unsigned mag [3];
      longint unsigned m, s, r, q;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
         u[i] = 0;
      end
      if (m == 0) return 1'b0;
      while (m >= (64'd1 << 24)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 23)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << UNIT_FRAC_BITS) + (r >> 1)) / r;
         if (q > UNIT) q = UNIT;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint round_to_unit(longint p);
      longint h, r;
      h = longint'(1) << (UNIT_FRAC_BITS - 1);
      if (p >= 0) r = (p + h) >>> UNIT_FRAC_BITS;
      else r = -(((-p) + h) >>> UNIT_FRAC_BITS);
      if (r > UNIT) r = UNIT;
      if (r < -UNIT) r = -UNIT;
      return r;
   endfunction

   function automatic frame_type frame_of(longint t [3], bit first, bit seg_deg, bit last);
      longint thr;
      bit use_x;
      bit deg;
      longint b [3];
      longint bn [3];
      longint nt [3];
      longint n [3];
      frame_type f;
      thr = first ? first_thr : rest_thr;
      thr = (UNIT_FRAC_BITS >= 14) ? thr << THR_SHL : thr >> THR_SHR;
      use_x = t[1] > thr;
      deg = seg_deg;
      if (use_x) begin
         b[0] = 0; b[1] = t[2]; b[2] = -t[1];
      end else begin
         b[0] = -t[2]; b[1] = 0; b[2] = t[0];
      end
      if (!make_unit(b, bn)) deg = 1'b1;
      for (int i = 0; i < 3; i++) nt[i] = (use_x && !first) ? -t[i] : t[i];
      n[0] = round_to_unit(bn[1] * nt[2] - bn[2] * nt[1]);
      n[1] = round_to_unit(bn[2] * nt[0] - bn[0] * nt[2]);
      n[2] = round_to_unit(bn[0] * nt[1] - bn[1] * nt[0]);
      f.tx = t[0][15:0]; f.ty = t[1][15:0]; f.tz = t[2][15:0];
      f.nx = n[0][15:0]; f.ny = n[1][15:0]; f.nz = n[2][15:0];
      f.bx = bn[0][15:0]; f.by = bn[1][15:0]; f.bz = bn[2][15:0];
      f.degenerate = deg;
      f.frame_last = last;
      return f;
   endfunction

   function automatic void restart_run();
      vtx_seen = 1'b0;
      first_pending = 1'b1;
      prev_tan[0] = UNIT;
      prev_tan[1] = 0;
      prev_tan[2] = 0;
   endfunction

   // advance the predictor by one accepted vertex
   function automatic void predict_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          bit last);
      longint v [3];
      longint d [3];
      longint t [3];
      bit seg_deg;
      v[0] = longint'(signed'(x));
      v[1] = longint'(signed'(y));
      v[2] = longint'(signed'(z));
      if (!vtx_seen) begin
         prev_vtx = v;
         vtx_seen = 1'b1;
         if (last) restart_run();
         return;
      end
      for (int i = 0; i < 3; i++) d[i] = v[i] - prev_vtx[i];
      seg_deg = !make_unit(d, t);
      if (seg_deg) t = prev_tan;
      frames_expected.push_back(frame_of(t, first_pending, seg_deg, 1'b0));
      first_pending = 1'b0;
      prev_tan = t;
      prev_vtx = v;
      if (last) begin
         frames_expected.push_back(frame_of(t, 1'b0, seg_deg, 1'b1));
         restart_run();
      end
   endfunction

   // send one vertex and keep the predictor in step; valid stays high after
   // acceptance until the next idle cycle or pause drops it
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertex(x, y, z, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (frames_expected.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_thresholds(int first_val, int rest_val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= REG_FIRST_UP_THR;
      csr_wdata <= first_val[THR_W-1:0];
      @(posedge clock);
      csr_index <= REG_REST_UP_THR;
      csr_wdata <= rest_val[THR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      first_thr = first_val;
      rest_thr = rest_val;
   endtask

   // receiver: random stall, then compare against the oldest expectation
   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      if (reset) rsp_tready <= 1'b0;
      else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tuser, rsp_tdata};
            if (frames_expected.size() == 0) begin
               $display("%0t: unexpected frame, actual %h", $time, got);
               errors++;
            end else begin
               want = frames_expected.pop_front();
               if (got !== want) begin
                  $display("%0t: frame mismatch, expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("FAIL polyline_tnb_frame_builder");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return 32'($signed($urandom_range(400000)) - 200000) <<< 8;
         default: return $urandom & 32'hFFFF_FF00;
      endcase
   endfunction

   // directed cases: extremes, zero segment, single vertex, axis switch
   task automatic test_directed();
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);  // zero segment
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
      send_vertex(32'h1234_0000, 32'h0, 32'h0, 1'b1);                  // single vertex
      // straight up the y axis: x-axis up vector, zero binormal cases nearby
      send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b0);
      send_vertex(32'h0, 32'h0002_0000, 32'h0, 1'b0);
      send_vertex(32'h0, 32'h0002_0000, 32'h0, 1'b1);                  // zero segment, last
      // down the y axis: zero binormal with y up
      send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0, 32'hFFFF_0000, 32'h0, 1'b0);
      send_vertex(32'h1, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1);
      // zero segment first in a run
      send_vertex(32'h5, 32'h5, 32'h5, 1'b0);
      send_vertex(32'h5, 32'h5, 32'h5, 1'b1);
      // nearly vertical, near the thresholds
      send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0000_0100, 32'h0010_0000, 32'h0000_0100, 1'b0);
      send_vertex(32'h0000_0200, 32'h0020_0000, 32'hFFFF_FF00, 1'b1);
   endtask

   task automatic test_random_runs(int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(15) == 0 && k > 0)
               send_vertex(prev_vtx[0][31:0], prev_vtx[1][31:0], prev_vtx[2][31:0],
                           k == len - 1);
            else if ($urandom_range(7) == 0 && k > 0)
               send_vertex(prev_vtx[0][31:0] + ($urandom_range(3) << 8),
                           prev_vtx[1][31:0] + 32'h0010_0000,
                           prev_vtx[2][31:0] - ($urandom_range(3) << 8), k == len - 1);
            else send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
            sent++;
         end
         // sender waits for the block to empty once in a while
         if ($urandom_range(40) == 0) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (frames_expected.size() != 0);
         end
      end
   endtask

   task automatic test_threshold_settings();
      write_thresholds(0, 0);
      test_random_runs(100);
      write_thresholds(16384, 16384);
      test_random_runs(100);
      write_thresholds(32767, 0);
      test_random_runs(60);
      write_thresholds(8192, 12000);
      test_random_runs(80);
      write_thresholds(16351, 16381);
   endtask

   initial begin
      restart_run();
      for (int i = 0; i < 3; i++) prev_vtx[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 28;
      recv_idle_pct = 46;
      test_directed();
      test_random_runs(200);
      send_idle_pct = 46;
      recv_idle_pct = 28;
      test_threshold_settings();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_runs(300);
      wait_drained();
      if (errors == 0) $display("PASS polyline_tnb_frame_builder");
      else $display("FAIL polyline_tnb_frame_builder");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
hdl/ptfb_pkg.sv
hdl/ptfb_ctrl.sv
hdl/ptfb_dpath.sv
hdl/polyline_tnb_frame_builder.sv
tb/sv/polyline_tnb_frame_builder_tb.sv
